/* design/ray_sphere_nearest_hit_top_assert.svh */
// assertion helpers for the ray/sphere block, clocked on i_clk, reset by i_rst_n
`ifndef RAY_SPHERE_NEAREST_HIT_TOP_ASSERT_SVH
`define RAY_SPHERE_NEAREST_HIT_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RSNH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define RSNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rsnh_pkg.sv */
package rsnh_pkg;

    localparam int DEFAULT_MAX_SPHERES = 16;

    localparam int COORD_W   = 24;
    localparam int RAD_W     = 23;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_REG_W = 5;
    localparam int DIST_W    = 23;
    localparam int ENTRY_W   = 3 * COORD_W + RAD_W;

    localparam int OPND_W = 27;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = 102;
    localparam int RADICAND_W = 100;
    localparam int ROOT_W = 50;
    localparam int NUM_W  = 63;
    localparam int DEN_W  = 48;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RAY   = 1'b1;

    typedef enum logic [1:0] {
        SHIFT_0,
        SHIFT_26,
        SHIFT_52
    } t_shift;

    typedef enum logic {
        MODE_SQRT,
        MODE_DIV
    } t_iter_mode;

    typedef struct packed {
        logic                      valid;
        logic                      clear;
        logic                      neg;
        t_shift                    shift;
        logic signed [OPND_W-1:0]  op_a;
        logic signed [OPND_W-1:0]  op_b;
    } t_mac_op;

endpackage

/* design/rsnh_ram.sv */
module rsnh_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rsnh_mac.sv */
module rsnh_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rsnh_pkg::t_mac_op                i_op,
    output logic signed [rsnh_pkg::ACC_W-1:0] o_acc
);
    import rsnh_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_mac_op                  r_ctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  term_ext;
    logic signed [ACC_W-1:0]  term_sh;
    logic signed [ACC_W-1:0]  base;

    // product stage, then shift and accumulate stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_op.op_a * i_op.op_b;
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl <= i_op;
        end
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        term_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        unique case (r_ctl.shift)
            SHIFT_0:  term_sh = term_ext;
            SHIFT_26: term_sh = term_ext <<< 26;
            SHIFT_52: term_sh = term_ext <<< 52;
            default:  term_sh = term_ext;
        endcase
        base  = r_ctl.clear ? '0 : r_acc;
        n_acc = r_ctl.neg ? (base - term_sh) : (base + term_sh);
    end

    assign o_acc = r_acc;

endmodule

/* design/rsnh_iter.sv */
module rsnh_iter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  rsnh_pkg::t_iter_mode              i_mode,
    input  logic [rsnh_pkg::RADICAND_W-1:0]   i_radicand,
    input  logic [rsnh_pkg::NUM_W-1:0]        i_num,
    input  logic [rsnh_pkg::DEN_W-1:0]        i_den,
    output logic                              o_done,
    output logic [rsnh_pkg::NUM_W-1:0]        o_result
);
    import rsnh_pkg::*;

    localparam int REM_W      = 54;
    localparam int SQRT_STEPS = RADICAND_W / 2;
    localparam int DIV_STEPS  = NUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    logic [RADICAND_W-1:0] r_shreg;
    logic [REM_W-1:0]      r_rem;
    logic [NUM_W-1:0]      r_q;
    logic [DEN_W-1:0]      r_den;
    logic [CNT_W-1:0]      r_cnt;
    t_iter_mode            r_mode;
    logic                  r_busy;
    logic                  r_done;

    logic [REM_W-1:0] x_val;
    logic [REM_W-1:0] y_val;
    logic [REM_W:0]   diff;
    logic             ge;

    // one restoring step per cycle, shared by root and quotient
    always_comb begin
        if (r_mode == MODE_SQRT) begin
            x_val = {r_rem[REM_W-3:0], r_shreg[RADICAND_W-1 -: 2]};
            y_val = {2'b00, r_q[ROOT_W-1:0], 2'b01};
        end else begin
            x_val = {r_rem[REM_W-2:0], r_shreg[RADICAND_W-1]};
            y_val = {{(REM_W-DEN_W){1'b0}}, r_den};
        end
        diff = {1'b0, x_val} - {1'b0, y_val};
        ge   = !diff[REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mode <= i_mode;
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_den;
                if (i_mode == MODE_SQRT) begin
                    r_shreg <= i_radicand;
                    r_cnt   <= CNT_W'(SQRT_STEPS);
                end else begin
                    r_shreg <= {i_num, {(RADICAND_W-NUM_W){1'b0}}};
                    r_cnt   <= CNT_W'(DIV_STEPS);
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[REM_W-1:0] : x_val;
                r_q   <= {r_q[NUM_W-2:0], ge};
                if (r_mode == MODE_SQRT) begin
                    r_shreg <= r_shreg << 2;
                end else begin
                    r_shreg <= r_shreg << 1;
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_q;

endmodule

/* design/ray_sphere_nearest_hit_top.sv */
// ray / sphere nearest hit
// command channel: an item transfers at a clock edge with start high and busy low.
// a write item (kind 0) stores one sphere at entry_index in the same cycle and
// gives no result; busy stays low. a ray item (kind 1) with spheres to test raises
// busy and tests spheres 0 .. min(sphere_count, MAX_SPHERES)-1 against the ray.
// the result shows for exactly one cycle with o_result_valid; the receiver cannot
// stall it, and busy is already low in that cycle.
// a ray with no sphere to test gives a miss result and leaves busy low.
// per sphere: table read, then 18 partial products of 27x27 bits on the shared
// multiply-accumulate unit, then the root and the division on the shared
// one-bit-per-cycle restoring unit, with check, root and next states between. a
// sphere that misses before the root or division skips those steps.
// one ray at a time: no new item is taken while busy is high.
// sphere_count lives in an apb register at addresses 0 to 3 (paddr[2] low); pready is always high.
// reset clears the sequencer and sphere_count; the sphere table is not cleared
// and must be written before a ray reads it.
module ray_sphere_nearest_hit_top #(
    parameter int MAX_SPHERES = rsnh_pkg::DEFAULT_MAX_SPHERES
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_kind,
    input  logic [3:0]                              i_entry_index,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_center_x,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_center_y,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_center_z,
    input  logic [rsnh_pkg::RAD_W-1:0]              i_sphere_radius,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_origin_x,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_origin_y,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_origin_z,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_dir_x,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_dir_y,
    input  logic signed [rsnh_pkg::COORD_W-1:0]     i_dir_z,
    output logic                                    o_result_valid,
    output logic                                    o_hit,
    output logic [rsnh_pkg::DIST_W-1:0]             o_distance,
    output logic [rsnh_pkg::IDX_OUT_W-1:0]          o_sphere_index,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import rsnh_pkg::*;

    `include "ray_sphere_nearest_hit_top_assert.svh"

    localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W = $clog2(MAX_SPHERES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_OC,
        S_MUL,
        S_ACC,
        S_CHECK,
        S_SQRT,
        S_ROOT,
        S_DIV,
        S_NEXT
    } t_state;

    typedef enum logic [4:0] {
        ST_DXX, ST_DYY, ST_DZZ,
        ST_OXD, ST_OYD, ST_OZD,
        ST_OXX, ST_OYY, ST_OZZ, ST_RR,
        ST_H00, ST_H01, ST_H10, ST_H11,
        ST_AC00, ST_AC01, ST_AC10, ST_AC11
    } t_step;

    t_state r_state;
    t_step  r_op;

    // configuration
    logic [CNT_REG_W-1:0] r_sphere_count;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_REG_W){1'b0}}, r_sphere_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sphere_count <= '0;
        end else if (cfg_wr) begin
            r_sphere_count <= pwdata[CNT_REG_W-1:0];
        end
    end

    // sphere table
    logic               accept;
    logic               tab_we;
    logic [ENTRY_W-1:0] tab_rdata;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_limit;
    logic [CNT_W-1:0]   limit_val;

    assign accept = start && !busy;
    assign tab_we = accept && (i_kind == KIND_WRITE) && (32'(i_entry_index) < MAX_SPHERES);
    assign limit_val = (32'(r_sphere_count) > MAX_SPHERES) ? CNT_W'(MAX_SPHERES)
                                                           : CNT_W'(r_sphere_count);

    rsnh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SPHERES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (IDX_W'(i_entry_index)),
        .i_wdata ({i_center_x, i_center_y, i_center_z, i_sphere_radius}),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (tab_rdata)
    );

    // ray and per-sphere operands
    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;
    logic signed [COORD_W:0]   r_ocx, r_ocy, r_ocz;
    logic [RAD_W-1:0]          r_rad;
    logic [DEN_W-1:0]          r_a;
    logic signed [50:0]        r_h;
    logic signed [51:0]        r_c;
    logic [ROOT_W-1:0]         r_s;
    logic [NUM_W-1:0]          r_best;
    logic [IDX_W-1:0]          r_best_idx;
    logic                      r_found;

    logic signed [COORD_W-1:0] tab_cx, tab_cy, tab_cz;
    logic [RAD_W-1:0]          tab_r;
    assign {tab_cx, tab_cy, tab_cz, tab_r} = tab_rdata;

    logic signed [51:0] h_ext;
    logic [51:0]        hm;
    logic [51:0]        cm;
    logic               c_pos;

    assign h_ext = 52'(r_h);
    assign hm    = r_h[50] ? 52'(-h_ext) : 52'(h_ext);
    assign cm    = r_c[51] ? 52'(-r_c) : 52'(r_c);
    assign c_pos = !r_c[51] && (r_c != '0);

    // shared multiply-accumulate
    t_mac_op                 mop;
    logic signed [ACC_W-1:0] acc;

    always_comb begin
        mop       = '0;
        mop.valid = (r_state == S_MUL);
        unique case (r_op)
            ST_DXX:  begin mop.clear = 1'b1; mop.op_a = 27'(r_dx); mop.op_b = 27'(r_dx); end
            ST_DYY:  begin mop.op_a = 27'(r_dy); mop.op_b = 27'(r_dy); end
            ST_DZZ:  begin mop.op_a = 27'(r_dz); mop.op_b = 27'(r_dz); end
            ST_OXD:  begin mop.clear = 1'b1; mop.op_a = 27'(r_ocx); mop.op_b = 27'(r_dx); end
            ST_OYD:  begin mop.op_a = 27'(r_ocy); mop.op_b = 27'(r_dy); end
            ST_OZD:  begin mop.op_a = 27'(r_ocz); mop.op_b = 27'(r_dz); end
            ST_OXX:  begin mop.clear = 1'b1; mop.op_a = 27'(r_ocx); mop.op_b = 27'(r_ocx); end
            ST_OYY:  begin mop.op_a = 27'(r_ocy); mop.op_b = 27'(r_ocy); end
            ST_OZZ:  begin mop.op_a = 27'(r_ocz); mop.op_b = 27'(r_ocz); end
            ST_RR:   begin
                mop.neg  = 1'b1;
                mop.op_a = $signed({4'b0, r_rad});
                mop.op_b = $signed({4'b0, r_rad});
            end
            // disc = h*h -/+ a*|c|, built from 26-bit limbs
            ST_H00:  begin
                mop.clear = 1'b1;
                mop.op_a  = $signed({1'b0, hm[25:0]});
                mop.op_b  = $signed({1'b0, hm[25:0]});
            end
            ST_H01:  begin
                mop.shift = SHIFT_26;
                mop.op_a  = $signed({1'b0, hm[25:0]});
                mop.op_b  = $signed({1'b0, hm[51:26]});
            end
            ST_H10:  begin
                mop.shift = SHIFT_26;
                mop.op_a  = $signed({1'b0, hm[51:26]});
                mop.op_b  = $signed({1'b0, hm[25:0]});
            end
            ST_H11:  begin
                mop.shift = SHIFT_52;
                mop.op_a  = $signed({1'b0, hm[51:26]});
                mop.op_b  = $signed({1'b0, hm[51:26]});
            end
            ST_AC00: begin
                mop.neg  = c_pos;
                mop.op_a = $signed({1'b0, r_a[25:0]});
                mop.op_b = $signed({1'b0, cm[25:0]});
            end
            ST_AC01: begin
                mop.neg   = c_pos;
                mop.shift = SHIFT_26;
                mop.op_a  = $signed({1'b0, r_a[25:0]});
                mop.op_b  = $signed({1'b0, cm[51:26]});
            end
            ST_AC10: begin
                mop.neg   = c_pos;
                mop.shift = SHIFT_26;
                mop.op_a  = $signed({5'b0, r_a[47:26]});
                mop.op_b  = $signed({1'b0, cm[25:0]});
            end
            ST_AC11: begin
                mop.neg   = c_pos;
                mop.shift = SHIFT_52;
                mop.op_a  = $signed({5'b0, r_a[47:26]});
                mop.op_b  = $signed({1'b0, cm[51:26]});
            end
            default: mop.op_a = '0;
        endcase
    end

    rsnh_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mop),
        .o_acc   (acc)
    );

    // shared root / quotient unit
    logic               disc_pos;
    logic signed [51:0] neg_h;
    logic signed [51:0] n_lo;
    logic signed [51:0] n_hi;
    logic [NUM_W-1:0]   num;
    logic               root_ok;
    logic               iter_start;
    t_iter_mode         iter_mode;
    logic               iter_done;
    logic [NUM_W-1:0]   iter_res;

    assign disc_pos = !acc[ACC_W-1] && (acc != '0);
    assign neg_h    = -h_ext;
    assign n_lo     = neg_h - $signed({2'b0, r_s});
    assign n_hi     = neg_h + $signed({2'b0, r_s});
    assign root_ok  = !n_lo[51] || !n_hi[51];
    // take the smaller root unless it lies behind the origin
    assign num      = !n_lo[51] ? {n_lo[50:0], 12'b0} : {n_hi[50:0], 12'b0};

    assign iter_start = ((r_state == S_CHECK) && disc_pos) || ((r_state == S_ROOT) && root_ok);
    assign iter_mode  = (r_state == S_ROOT) ? MODE_DIV : MODE_SQRT;

    rsnh_iter u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (iter_start),
        .i_mode     (iter_mode),
        .i_radicand (acc[RADICAND_W-1:0]),
        .i_num      (num),
        .i_den      (r_a),
        .o_done     (iter_done),
        .o_result   (iter_res)
    );

    logic last_sphere;
    assign last_sphere = (CNT_W'(r_idx + 1'b1) == r_limit);

    // sequencer state and result outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_op           <= ST_DXX;
            busy           <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_kind == KIND_RAY)) begin
                        if (limit_val == '0) begin
                            o_result_valid <= 1'b1;
                            o_hit          <= 1'b0;
                            o_distance     <= '0;
                            o_sphere_index <= '0;
                        end else begin
                            busy    <= 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ:  r_state <= S_OC;
                S_OC: begin
                    r_op    <= ST_DXX;
                    r_state <= S_MUL;
                end
                S_MUL:   r_state <= S_ACC;
                S_ACC: begin
                    if (r_op == ST_AC11) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_op    <= t_step'(r_op + 1'b1);
                        r_state <= S_MUL;
                    end
                end
                S_CHECK: r_state <= disc_pos ? S_SQRT : S_NEXT;
                S_SQRT: begin
                    if (iter_done) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT:  r_state <= root_ok ? S_DIV : S_NEXT;
                S_DIV: begin
                    if (iter_done) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (last_sphere) begin
                        busy           <= 1'b0;
                        o_result_valid <= 1'b1;
                        o_hit          <= r_found;
                        o_distance     <= !r_found ? '0 :
                                          (r_best > NUM_W'(DIST_MAX)) ? DIST_MAX
                                                                      : r_best[DIST_W-1:0];
                        o_sphere_index <= r_found ? IDX_OUT_W'(r_best_idx) : '0;
                        r_state        <= S_IDLE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath captures
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            if ((r_state == S_IDLE) && accept && (i_kind == KIND_RAY)) begin
                r_found <= 1'b0;
                r_idx   <= '0;
                r_limit <= limit_val;
                r_ox    <= i_origin_x;
                r_oy    <= i_origin_y;
                r_oz    <= i_origin_z;
                r_dx    <= i_dir_x;
                r_dy    <= i_dir_y;
                r_dz    <= i_dir_z;
            end
            if (r_state == S_OC) begin
                r_ocx <= (COORD_W+1)'(r_ox) - (COORD_W+1)'(tab_cx);
                r_ocy <= (COORD_W+1)'(r_oy) - (COORD_W+1)'(tab_cy);
                r_ocz <= (COORD_W+1)'(r_oz) - (COORD_W+1)'(tab_cz);
                r_rad <= tab_r;
            end
            // the accumulator holds the previous group's sum when the next group opens
            if (r_state == S_MUL) begin
                if (r_op == ST_OXD) begin
                    r_a <= acc[DEN_W-1:0];
                end
                if (r_op == ST_OXX) begin
                    r_h <= acc[50:0];
                end
                if (r_op == ST_H00) begin
                    r_c <= acc[51:0];
                end
            end
            if ((r_state == S_SQRT) && iter_done) begin
                r_s <= iter_res[ROOT_W-1:0];
            end
            // strict compare keeps the lowest index on a tie
            if ((r_state == S_DIV) && iter_done && (!r_found || (iter_res < r_best))) begin
                r_found    <= 1'b1;
                r_best     <= iter_res;
                r_best_idx <= r_idx[IDX_W-1:0];
            end
            if ((r_state == S_NEXT) && !last_sphere) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    `RSNH_ASSERT_SAME(a_result_not_busy, o_result_valid, !busy, "result shown while busy")
    `RSNH_ASSERT_NEXT(a_ray_starts, accept && (i_kind == KIND_RAY), busy || o_result_valid, "ray transfer lost")
    `RSNH_ASSERT_SAME(a_miss_zero, o_result_valid && !o_hit, (o_distance == '0) && (o_sphere_index == '0), "miss result not zero")
    `RSNH_ASSERT_SAME(a_iter_done_state, iter_done, (r_state == S_SQRT) || (r_state == S_DIV), "iterative unit finished out of sequence")

endmodule
